@@ rtl/core/cch_pkg.sv @@
package cch_pkg;

   // Defaults for the top-level parameters.
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ANGLE_FRAC_DEF   = 7;

   // Fixed widths of the datapath.
   localparam int FIELD_W  = 16;  // raw sample, offsets, scales, min/max trackers
   localparam int DIFF_W   = FIELD_W + 1;
   localparam int PROD_W   = DIFF_W + FIELD_W;  // corrected sample
   localparam int CORDIC_W = 36;  // corrected sample with CORDIC gain and headroom
   localparam int DEG_FRAC = 16;  // fraction bits of the CORDIC angle in degrees
   localparam int ANGLE_W  = 27;  // CORDIC angle, signed
   localparam int HEAD_W   = 22;  // heading before clamping, signed
   localparam int ATAN_IDX_W = 5;

   // Scale ratio division.
   localparam int Q_FRAC = 12;
   localparam int QUOT_W = 15;
   localparam int DIV_W  = 31;

   localparam logic signed [FIELD_W-1:0] Q_ONE          = 16'sd4096;
   localparam logic signed [FIELD_W-1:0] Q_MAX          = 16'sd32767;
   localparam logic signed [FIELD_W-1:0] TRACK_MIN_INIT = 16'sh7FFF;
   localparam logic signed [FIELD_W-1:0] TRACK_MAX_INIT = 16'sh8000;

   typedef enum logic [1:0] {
      CMD_SAMPLE    = 2'd0,
      CMD_CAL_START = 2'd1,
      CMD_CAL_END   = 2'd2
   } cmd_type;

   // atan(2^-i) in degrees with DEG_FRAC fraction bits.
   function automatic logic signed [ANGLE_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
      case (idx)
         5'd0:    atan_q16 = ANGLE_W'(2949120);
         5'd1:    atan_q16 = ANGLE_W'(1740967);
         5'd2:    atan_q16 = ANGLE_W'(919879);
         5'd3:    atan_q16 = ANGLE_W'(466945);
         5'd4:    atan_q16 = ANGLE_W'(234379);
         5'd5:    atan_q16 = ANGLE_W'(117304);
         5'd6:    atan_q16 = ANGLE_W'(58666);
         5'd7:    atan_q16 = ANGLE_W'(29335);
         5'd8:    atan_q16 = ANGLE_W'(14668);
         5'd9:    atan_q16 = ANGLE_W'(7334);
         5'd10:   atan_q16 = ANGLE_W'(3667);
         5'd11:   atan_q16 = ANGLE_W'(1833);
         5'd12:   atan_q16 = ANGLE_W'(917);
         5'd13:   atan_q16 = ANGLE_W'(458);
         5'd14:   atan_q16 = ANGLE_W'(229);
         5'd15:   atan_q16 = ANGLE_W'(115);
         5'd16:   atan_q16 = ANGLE_W'(57);
         5'd17:   atan_q16 = ANGLE_W'(29);
         5'd18:   atan_q16 = ANGLE_W'(14);
         5'd19:   atan_q16 = ANGLE_W'(7);
         5'd20:   atan_q16 = ANGLE_W'(4);
         5'd21:   atan_q16 = ANGLE_W'(2);
         5'd22:   atan_q16 = ANGLE_W'(1);
         default: atan_q16 = '0;
      endcase
   endfunction

endpackage

@@ rtl/core/cch_cordic.sv @@
module cch_cordic
   import cch_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [PROD_W-1:0]  x_in,
   input  logic signed [PROD_W-1:0]  y_in,
   output logic                      done,
   output logic signed [ANGLE_W-1:0] angle
);

   localparam int CW = $clog2(CORDIC_STEPS);

   logic [CW-1:0]              cnt_ff, cnt_in;
   logic                       running_ff, running_in;
   logic                       done_ff, done_in;
   logic                       zero_ff, zero_in;
   logic signed [CORDIC_W-1:0] x_ff, x_in_n, y_ff, y_in_n;
   logic signed [ANGLE_W-1:0]  z_ff, z_in;
   logic signed [CORDIC_W-1:0] x_ext, y_ext, x_sh, y_sh;

   assign x_ext = CORDIC_W'(x_in);
   assign y_ext = CORDIC_W'(y_in);
   assign x_sh  = x_ff >>> cnt_ff;
   assign y_sh  = y_ff >>> cnt_ff;

   always_comb begin
      cnt_in     = cnt_ff;
      running_in = running_ff;
      done_in    = 1'b0;
      zero_in    = zero_ff;
      x_in_n     = x_ff;
      y_in_n     = y_ff;
      z_in       = z_ff;
      if (start) begin
         cnt_in     = '0;
         running_in = 1'b1;
         zero_in    = (x_in == '0) && (y_in == '0);
         // Bring a vector in the left half plane over by a quarter turn.
         if (x_ext < 0) begin
            if (y_ext >= 0) begin
               x_in_n = y_ext;
               y_in_n = -x_ext;
               z_in   = ANGLE_W'(90 <<< DEG_FRAC);
            end else begin
               x_in_n = -y_ext;
               y_in_n = x_ext;
               z_in   = -ANGLE_W'(90 <<< DEG_FRAC);
            end
         end else begin
            x_in_n = x_ext;
            y_in_n = y_ext;
            z_in   = '0;
         end
      end else if (running_ff) begin
         if (y_ff >= 0) begin
            x_in_n = x_ff + y_sh;
            y_in_n = y_ff - x_sh;
            z_in   = z_ff + atan_q16(ATAN_IDX_W'(cnt_ff));
         end else begin
            x_in_n = x_ff - y_sh;
            y_in_n = y_ff + x_sh;
            z_in   = z_ff - atan_q16(ATAN_IDX_W'(cnt_ff));
         end
         if (cnt_ff == CW'(CORDIC_STEPS - 1)) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
         cnt_ff     <= cnt_in;
      end
      zero_ff <= zero_in;
      x_ff    <= x_in_n;
      y_ff    <= y_in_n;
      z_ff    <= z_in;
   end

   assign done  = done_ff;
   assign angle = zero_ff ? '0 : z_ff;

endmodule

@@ rtl/core/cch_divider.sv @@
module cch_divider
   import cch_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [FIELD_W-1:0] dividend,
   input  logic [FIELD_W-1:0] divisor,
   output logic               done,
   output logic [QUOT_W-1:0]  quotient
);

   localparam int CW = $clog2(QUOT_W);

   logic [DIV_W-1:0]  rem_ff, rem_in, dsh_ff, dsh_in;
   logic [QUOT_W-1:0] q_ff, q_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              running_ff, running_in;
   logic              done_ff, done_in;

   // The caller guarantees a quotient below 2^QUOT_W, so the divisor starts
   // aligned to the top quotient bit.
   always_comb begin
      rem_in     = rem_ff;
      dsh_in     = dsh_ff;
      q_in       = q_ff;
      cnt_in     = cnt_ff;
      running_in = running_ff;
      done_in    = 1'b0;
      if (start) begin
         rem_in     = DIV_W'({dividend, {Q_FRAC{1'b0}}});
         dsh_in     = DIV_W'({divisor, {(QUOT_W - 1){1'b0}}});
         q_in       = '0;
         cnt_in     = '0;
         running_in = 1'b1;
      end else if (running_ff) begin
         if (rem_ff >= dsh_ff) begin
            rem_in = rem_ff - dsh_ff;
            q_in   = {q_ff[QUOT_W-2:0], 1'b1};
         end else begin
            q_in = {q_ff[QUOT_W-2:0], 1'b0};
         end
         dsh_in = dsh_ff >> 1;
         if (cnt_ff == CW'(QUOT_W - 1)) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
         cnt_ff     <= cnt_in;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

@@ rtl/core/calibrated_compass_heading_top.sv @@
// Calibrated compass heading.
// The req channel takes one item per command: req_tuser carries the command
// (sample, start calibration, end calibration), req_tdata the raw X and Y
// field readings. Every item gives exactly one item on the rsp channel.
// A sample updates the min/max trackers, is corrected with the stored offsets
// and scales by one shared multiplier, and its angle is found by
// an iterative CORDIC that does one micro-rotation a cycle. Declination comes
// in through the csr channel, which is always ready.
// A sample result is loaded into the output register after the multiplier,
// CORDIC and wrap steps, an end calibration after the 15-step ratio divider
// unless it saturates or has equal ranges, and any other command directly.
// req_tready is high only while the sequencer is idle, so a new item can be
// taken no earlier than the cycle after the previous result has been loaded
// into the output register.
// The output register holds its item while rsp_tready is low; the next item
// may be accepted meanwhile but its result waits until the register is free.
// Reset clears the trackers to their empty state, the offsets to zero, both
// scales to one and the declination to zero; no clearing pass is needed.
module calibrated_compass_heading_top
   import cch_pkg::*;
#(
   parameter int CORDIC_STEPS        = CORDIC_STEPS_DEF,
   parameter int ANGLE_FRACTION_BITS = ANGLE_FRAC_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // field_x [15:0], field_y [31:16]
   input  logic [1:0]  req_tuser,   // command [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // heading [15:0]
   output logic [1:0]  rsp_tuser,   // heading_valid [0], scale_clipped [1]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data     // declination [15:0]
);

   localparam int SH = DEG_FRAC - ANGLE_FRACTION_BITS;
   localparam logic signed [ANGLE_W-1:0] ROUND_HALF = ANGLE_W'(1 <<< (SH - 1));
   localparam logic signed [HEAD_W-1:0]  FULL       =
      HEAD_W'(360 <<< ANGLE_FRACTION_BITS);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_X,
      ST_MUL_Y,
      ST_START,
      ST_ITER,
      ST_WRAP,
      ST_CAL,
      ST_DIV,
      ST_DELIVER
   } state_type;

   state_type state_ff, state_in;

   logic signed [FIELD_W-1:0] fx_ff, fx_in, fy_ff, fy_in;
   logic signed [FIELD_W-1:0] min_x_ff, min_x_in, max_x_ff, max_x_in;
   logic signed [FIELD_W-1:0] min_y_ff, min_y_in, max_y_ff, max_y_in;
   logic signed [FIELD_W-1:0] offset_x_ff, offset_x_in, offset_y_ff, offset_y_in;
   logic signed [FIELD_W-1:0] scale_x_ff, scale_x_in, scale_y_ff, scale_y_in;
   logic signed [FIELD_W-1:0] decl_ff, decl_in;
   logic signed [PROD_W-1:0]  cx_ff, cx_in, cy_ff, cy_in;
   logic signed [HEAD_W-1:0]  h_ff, h_in;
   logic                      res_valid_ff, res_valid_in;
   logic                      res_clip_ff, res_clip_in;
   logic                      wide_y_ff, wide_y_in;
   logic                      rsp_tvalid_ff, rsp_tvalid_in;
   logic [15:0]               rsp_tdata_ff, rsp_tdata_in;
   logic [1:0]                rsp_tuser_ff, rsp_tuser_in;

   logic signed [FIELD_W-1:0] req_x, req_y;
   logic signed [DIFF_W-1:0]  diff_x, diff_y, mul_a;
   logic signed [FIELD_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod;

   logic                      cordic_start, cordic_done;
   logic signed [ANGLE_W-1:0] angle, angle_rnd, angle_sh;
   logic signed [HEAD_W-1:0]  h_round, h_clamp;

   logic signed [DIFF_W-1:0]  dx, dy, sum_x, sum_y, sum_x_adj, sum_y_adj;
   logic [FIELD_W-1:0]        rx, ry, wide, narrow;
   logic                      ratio_sat;
   logic                      div_start, div_done;
   logic [QUOT_W-1:0]         quotient;

   assign req_x = req_tdata[15:0];
   assign req_y = req_tdata[31:16];

   // Shared multiplier for the offset and scale correction.
   assign diff_x = DIFF_W'(fx_ff) - DIFF_W'(offset_x_ff);
   assign diff_y = DIFF_W'(fy_ff) - DIFF_W'(offset_y_ff);
   assign mul_a  = (state_ff == ST_MUL_X) ? diff_x : diff_y;
   assign mul_b  = (state_ff == ST_MUL_X) ? scale_x_ff : scale_y_ff;
   assign prod   = PROD_W'(mul_a) * PROD_W'(mul_b);

   // Round the CORDIC angle half up to heading units and add declination.
   assign angle_rnd = angle + ROUND_HALF;
   assign angle_sh  = angle_rnd >>> SH;
   assign h_round   = HEAD_W'(angle_sh) + HEAD_W'(decl_ff);

   always_comb begin
      if (h_ff < 0) begin
         h_clamp = '0;
      end else if (h_ff > FULL) begin
         h_clamp = FULL;
      end else begin
         h_clamp = h_ff;
      end
   end

   // Calibration arithmetic; a range with max below min counts as zero.
   assign dx        = DIFF_W'(max_x_ff) - DIFF_W'(min_x_ff);
   assign dy        = DIFF_W'(max_y_ff) - DIFF_W'(min_y_ff);
   assign rx        = dx[DIFF_W-1] ? '0 : dx[FIELD_W-1:0];
   assign ry        = dy[DIFF_W-1] ? '0 : dy[FIELD_W-1:0];
   assign sum_x     = DIFF_W'(max_x_ff) + DIFF_W'(min_x_ff);
   assign sum_y     = DIFF_W'(max_y_ff) + DIFF_W'(min_y_ff);
   assign sum_x_adj = sum_x + DIFF_W'({1'b0, sum_x[DIFF_W-1]});
   assign sum_y_adj = sum_y + DIFF_W'({1'b0, sum_y[DIFF_W-1]});
   assign wide      = (ry > rx) ? ry : rx;
   assign narrow    = (ry > rx) ? rx : ry;
   // The ratio reaches 2^QUOT_W exactly when wide is at least eight times narrow.
   assign ratio_sat = {3'b000, wide} >= {narrow, 3'b000};

   always_comb begin
      state_in      = state_ff;
      fx_in         = fx_ff;
      fy_in         = fy_ff;
      min_x_in      = min_x_ff;
      max_x_in      = max_x_ff;
      min_y_in      = min_y_ff;
      max_y_in      = max_y_ff;
      offset_x_in   = offset_x_ff;
      offset_y_in   = offset_y_ff;
      scale_x_in    = scale_x_ff;
      scale_y_in    = scale_y_ff;
      decl_in       = decl_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      h_in          = h_ff;
      res_valid_in  = res_valid_ff;
      res_clip_in   = res_clip_ff;
      wide_y_in     = wide_y_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      cordic_start  = 1'b0;
      div_start     = 1'b0;

      if (csr_valid) begin
         decl_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               fx_in        = req_x;
               fy_in        = req_y;
               h_in         = '0;
               res_valid_in = 1'b0;
               res_clip_in  = 1'b0;
               case (cmd_type'(req_tuser))
                  CMD_SAMPLE: begin
                     if (req_x < min_x_ff) min_x_in = req_x;
                     if (req_x > max_x_ff) max_x_in = req_x;
                     if (req_y < min_y_ff) min_y_in = req_y;
                     if (req_y > max_y_ff) max_y_in = req_y;
                     state_in = ST_MUL_X;
                  end
                  CMD_CAL_START: begin
                     min_x_in = TRACK_MIN_INIT;
                     min_y_in = TRACK_MIN_INIT;
                     max_x_in = TRACK_MAX_INIT;
                     max_y_in = TRACK_MAX_INIT;
                     state_in = ST_DELIVER;
                  end
                  CMD_CAL_END: begin
                     state_in = ST_CAL;
                  end
                  default: begin
                     state_in = ST_DELIVER;
                  end
               endcase
            end
         end
         ST_MUL_X: begin
            cx_in    = prod;
            state_in = ST_MUL_Y;
         end
         ST_MUL_Y: begin
            cy_in    = prod;
            state_in = ST_START;
         end
         ST_START: begin
            cordic_start = 1'b1;
            state_in     = ST_ITER;
         end
         ST_ITER: begin
            if (cordic_done) begin
               h_in     = h_round;
               state_in = ST_WRAP;
            end
         end
         ST_WRAP: begin
            if (h_ff < 0) begin
               h_in = h_ff + FULL;
            end else if (h_ff > FULL) begin
               h_in = h_ff - FULL;
            end
            res_valid_in = 1'b1;
            state_in     = ST_DELIVER;
         end
         ST_CAL: begin
            offset_x_in = sum_x_adj[DIFF_W-1:1];
            offset_y_in = sum_y_adj[DIFF_W-1:1];
            wide_y_in   = ry > rx;
            if (rx == ry) begin
               scale_x_in = Q_ONE;
               scale_y_in = Q_ONE;
               state_in   = ST_DELIVER;
            end else begin
               if (ry > rx) begin
                  scale_y_in = Q_ONE;
               end else begin
                  scale_x_in = Q_ONE;
               end
               if (ratio_sat) begin
                  if (ry > rx) begin
                     scale_x_in = Q_MAX;
                  end else begin
                     scale_y_in = Q_MAX;
                  end
                  res_clip_in = 1'b1;
                  state_in    = ST_DELIVER;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               if (wide_y_ff) begin
                  scale_x_in = FIELD_W'(quotient);
               end else begin
                  scale_y_in = FIELD_W'(quotient);
               end
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = h_clamp[15:0];
               rsp_tuser_in  = {res_clip_ff, res_valid_ff};
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         min_x_ff      <= TRACK_MIN_INIT;
         min_y_ff      <= TRACK_MIN_INIT;
         max_x_ff      <= TRACK_MAX_INIT;
         max_y_ff      <= TRACK_MAX_INIT;
         offset_x_ff   <= '0;
         offset_y_ff   <= '0;
         scale_x_ff    <= Q_ONE;
         scale_y_ff    <= Q_ONE;
         decl_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         min_x_ff      <= min_x_in;
         min_y_ff      <= min_y_in;
         max_x_ff      <= max_x_in;
         max_y_ff      <= max_y_in;
         offset_x_ff   <= offset_x_in;
         offset_y_ff   <= offset_y_in;
         scale_x_ff    <= scale_x_in;
         scale_y_ff    <= scale_y_in;
         decl_ff       <= decl_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      fx_ff        <= fx_in;
      fy_ff        <= fy_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      h_ff         <= h_in;
      res_valid_ff <= res_valid_in;
      res_clip_ff  <= res_clip_in;
      wide_y_ff    <= wide_y_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   cch_cordic #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .x_in  (cx_ff),
      .y_in  (cy_ff),
      .done  (cordic_done),
      .angle (angle)
   );

   cch_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (wide),
      .divisor  (narrow),
      .done     (div_done),
      .quotient (quotient)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign csr_ready  = 1'b1;

   a_nonsample_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 16'd0)
      else $error("result without a heading carries a non-zero heading");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("heading and clipped flags set together");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item accepted while one is in progress");

   a_cordic_in_iter: assert property (@(posedge clock) disable iff (reset)
      cordic_done |-> state_ff == ST_ITER)
      else $error("CORDIC finished outside its iteration phase");

endmodule

@@ dv/tb_top.sv @@
module tb_top;
   import cch_pkg::*;

   // Command 3 has no meaning; the block must leave its state alone and return zeros.
   localparam logic [1:0] CMD_UNUSED  = 2'd3;
   localparam int ROUND_SHIFT  = DEG_FRAC - ANGLE_FRAC_DEF;
   localparam int FULL_CIRCLE  = 360 << ANGLE_FRAC_DEF;
   localparam int STALL_LIMIT  = 2000;

   typedef struct packed {
      logic [1:0]         command;
      logic signed [15:0] field_x;
      logic signed [15:0] field_y;
   } compass_item_type;

   typedef struct packed {
      logic [15:0] heading;
      logic        heading_valid;
      logic        scale_clipped;
   } heading_result_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // field_x [15:0], field_y [31:16]
   logic [1:0]  req_tuser = '0;   // command [1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // heading [15:0]
   logic [1:0]  rsp_tuser;        // heading_valid [0], scale_clipped [1]
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;    // declination [15:0]

   calibrated_compass_heading_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // Calibration state as the block should hold it.
   int min_x = 32767;
   int max_x = -32768;
   int min_y = 32767;
   int max_y = -32768;
   int off_x = 0;
   int off_y = 0;
   int scale_x = 4096;
   int scale_y = 4096;
   int decl_units = 0;

   // atan(2^-i) in degrees, 16 fraction bits.
   longint atan_deg_table [0:15] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115
   };

   compass_item_type   pending_items [$];
   heading_result_type results_due [$];
   compass_item_type   on_bus = '0;
   int                 req_gap = 0;
   int                 rsp_stall = 0;
   int                 idle_cycles = 0;
   int                 mismatches = 0;
   logic               steady_flow = 1'b0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int q12_ratio(input int wide, input int narrow, output logic clip);
      longint q;
      clip = 1'b0;
      if (narrow <= 0) begin
         clip = 1'b1;
         return 32767;
      end
      q = (longint'(wide) * 4096) / narrow;
      if (q > 32767) begin
         clip = 1'b1;
         return 32767;
      end
      return int'(q);
   endfunction

   function automatic heading_result_type predict_heading(input compass_item_type it);
      heading_result_type r;
      longint cx, cy, ang, h, t, xs, ys;
      int fx, fy, rx, ry;
      logic clip;
      r = '0;
      clip = 1'b0;
      fx = $signed(it.field_x);
      fy = $signed(it.field_y);
      case (it.command)
         CMD_SAMPLE: begin
            if (fx < min_x) min_x = fx;
            if (fx > max_x) max_x = fx;
            if (fy < min_y) min_y = fy;
            if (fy > max_y) max_y = fy;
            cx = longint'(fx - off_x) * scale_x;
            cy = longint'(fy - off_y) * scale_y;
            ang = 0;
            if (cx != 0 || cy != 0) begin
               // Fold the left half plane over before the micro-rotations.
               if (cx < 0) begin
                  t = cx;
                  if (cy >= 0) begin
                     cx = cy;
                     cy = -t;
                     ang = longint'(90) << DEG_FRAC;
                  end else begin
                     cx = -cy;
                     cy = t;
                     ang = -(longint'(90) << DEG_FRAC);
                  end
               end
               for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
                  xs = cx >>> i;
                  ys = cy >>> i;
                  if (cy >= 0) begin
                     cx += ys;
                     cy -= xs;
                     ang += atan_deg_table[i];
                  end else begin
                     cx -= ys;
                     cy += xs;
                     ang -= atan_deg_table[i];
                  end
               end
            end
            h = ((ang + (longint'(1) << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT) + decl_units;
            if (h < 0) h += FULL_CIRCLE;
            else if (h > FULL_CIRCLE) h -= FULL_CIRCLE;
            if (h < 0) h = 0;
            if (h > FULL_CIRCLE) h = FULL_CIRCLE;
            r.heading = 16'(h);
            r.heading_valid = 1'b1;
         end
         CMD_CAL_START: begin
            min_x = 32767;
            min_y = 32767;
            max_x = -32768;
            max_y = -32768;
         end
         CMD_CAL_END: begin
            rx = (max_x >= min_x) ? max_x - min_x : 0;
            ry = (max_y >= min_y) ? max_y - min_y : 0;
            off_x = (max_x + min_x) / 2;
            off_y = (max_y + min_y) / 2;
            if (rx == ry) begin
               scale_x = 4096;
               scale_y = 4096;
            end else if (ry > rx) begin
               scale_y = 4096;
               scale_x = q12_ratio(ry, rx, clip);
            end else begin
               scale_x = 4096;
               scale_y = q12_ratio(rx, ry, clip);
            end
            r.scale_clipped = clip;
         end
         default: ;
      endcase
      return r;
   endfunction

   // Request side: present queued items, with short random pauses between them unless steady_flow is set.
   always @(posedge clock) begin : drive_req
      logic offer;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
      end else begin
         offer = req_tvalid;
         if (req_tvalid && req_tready) begin
            results_due.push_back(predict_heading(on_bus));
            offer = 1'b0;
         end
         if (!offer) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_items.size() > 0) begin
               on_bus = pending_items.pop_front();
               req_tdata <= {on_bus.field_y, on_bus.field_x};
               req_tuser <= on_bus.command;
               offer = 1'b1;
               if (!steady_flow && $urandom_range(0, 3) == 0)
                  req_gap = $urandom_range(1, 5);
            end
         end
         req_tvalid <= offer;
      end
   end

   // Response side: compare each item with the oldest prediction.
   always @(posedge clock) begin : watch_rsp
      heading_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (results_due.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected item, expected none, got heading %0d flags %b",
                        $time, rsp_tdata, rsp_tuser);
            end else begin
               want = results_due.pop_front();
               if (rsp_tdata !== want.heading) begin
                  mismatches++;
                  $display("%0t: heading expected %0d, got %0d",
                           $time, want.heading, rsp_tdata);
               end
               if (rsp_tuser[0] !== want.heading_valid) begin
                  mismatches++;
                  $display("%0t: heading_valid expected %b, got %b",
                           $time, want.heading_valid, rsp_tuser[0]);
               end
               if (rsp_tuser[1] !== want.scale_clipped) begin
                  mismatches++;
                  $display("%0t: scale_clipped expected %b, got %b",
                           $time, want.scale_clipped, rsp_tuser[1]);
               end
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!steady_flow && $urandom_range(0, 5) == 0)
               rsp_stall = $urandom_range(1, 5);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic enqueue(input logic [1:0] cmd, input int x, input int y);
      compass_item_type it;
      it.command = cmd;
      it.field_x = 16'(x);
      it.field_y = 16'(y);
      pending_items.push_back(it);
   endtask

   function automatic int near(input int centre, input int spread);
      int v;
      v = centre + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < -32768) v = -32768;
      if (v > 32767) v = 32767;
      return v;
   endfunction

   function automatic int random_spread();
      case ($urandom_range(0, 3))
         0:       return $urandom_range(0, 40);
         1:       return $urandom_range(0, 2000);
         2:       return $urandom_range(0, 12000);
         default: return $urandom_range(0, 40000);
      endcase
   endfunction

   function automatic int any_field();
      return int'($urandom_range(0, 65535));
   endfunction

   task automatic set_declination(input int v);
      logic signed [15:0] dv;
      dv = 16'(v);
      @(posedge clock);
      csr_data <= dv;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      decl_units = dv;
   endtask

   task automatic wait_drained();
      while (pending_items.size() != 0 || req_tvalid || results_due.size() != 0)
         @(posedge clock);
   endtask

   // Mostly whole calibration runs (start, samples around a centre, end, then
   // headings), with some stray commands of any kind mixed in.
   task automatic random_traffic(input int n);
      int made, cx0, cy0, sx, sy, k, m;
      made = 0;
      while (made < n) begin
         if ($urandom_range(0, 9) < 7) begin
            cx0 = int'($urandom_range(0, 40000)) - 20000;
            cy0 = int'($urandom_range(0, 40000)) - 20000;
            sx = random_spread();
            sy = random_spread();
            k = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 10);
            m = $urandom_range(2, 8);
            enqueue(CMD_CAL_START, any_field(), any_field());
            repeat (k) enqueue(CMD_SAMPLE, near(cx0, sx), near(cy0, sy));
            enqueue(CMD_CAL_END, any_field(), any_field());
            repeat (m) begin
               if ($urandom_range(0, 1) == 0)
                  enqueue(CMD_SAMPLE, near(cx0, sx), near(cy0, sy));
               else
                  enqueue(CMD_SAMPLE, any_field(), any_field());
            end
            made += k + m + 2;
         end else begin
            repeat ($urandom_range(1, 4)) begin
               enqueue(2'($urandom_range(0, 3)), any_field(), any_field());
               made++;
            end
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      set_declination(0);
      enqueue(CMD_SAMPLE, 0, 0);
      enqueue(CMD_SAMPLE, 32767, 0);
      enqueue(CMD_SAMPLE, -32768, 0);
      enqueue(CMD_SAMPLE, 0, -32768);
      enqueue(CMD_SAMPLE, -32768, -32768);
      enqueue(CMD_SAMPLE, 32767, 32767);
      enqueue(CMD_UNUSED, -1, -1);
      // End of calibration with no samples since its start.
      enqueue(CMD_CAL_START, 0, 0);
      enqueue(CMD_CAL_END, 0, 0);
      // Y never moves: its range is zero, so its scale saturates.
      enqueue(CMD_CAL_START, 0, 0);
      enqueue(CMD_SAMPLE, -1000, 10);
      enqueue(CMD_SAMPLE, 1000, 10);
      enqueue(CMD_CAL_END, 0, 0);
      enqueue(CMD_SAMPLE, 5, 20);
      // A ratio of exactly eight is one step past the Q4.12 maximum.
      enqueue(CMD_CAL_START, 0, 0);
      enqueue(CMD_SAMPLE, -8000, -1000);
      enqueue(CMD_SAMPLE, 8000, 1000);
      enqueue(CMD_CAL_END, 0, 0);
      enqueue(CMD_SAMPLE, -300, 900);
      enqueue(CMD_CAL_START, 0, 0);
      enqueue(CMD_SAMPLE, -1000, -4000);
      enqueue(CMD_SAMPLE, 1000, 4000);
      enqueue(CMD_CAL_END, 0, 0);
      enqueue(CMD_SAMPLE, 300, -200);
      // Equal full-scale ranges; the midpoint truncates to zero.
      enqueue(CMD_CAL_START, 0, 0);
      enqueue(CMD_SAMPLE, -32768, -32768);
      enqueue(CMD_SAMPLE, 32767, 32767);
      enqueue(CMD_CAL_END, 0, 0);
      enqueue(CMD_SAMPLE, 0, 0);
      wait_drained();

      set_declination(-23040);
      random_traffic(70);
      wait_drained();
      set_declination(23040);
      random_traffic(70);
      wait_drained();
      set_declination(int'($urandom_range(0, 46080)) - 23040);
      random_traffic(70);
      wait_drained();
      // Declinations beyond half a circle, so that one wrap is not always enough.
      set_declination(32767);
      random_traffic(30);
      wait_drained();
      set_declination(-32768);
      random_traffic(30);
      wait_drained();

      steady_flow = 1'b1;
      set_declination(int'($urandom_range(0, 46080)) - 23040);
      random_traffic(100);
      wait_drained();
      repeat (40) @(posedge clock);

      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
